### sv/vbn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbn_pkg
// Shared types and constants for the vertex bounding-box normalizer.
// ----------------------------------------------------------------------------
package vbn_pkg;

    localparam int COORD_W = 32;            // Q16.16 coordinate
    localparam int NORM_W  = 16;            // Q2.14 result
    localparam int INDEX_W = 10;            // read index field
    localparam int AXES    = 3;
    localparam int QBITS   = 16;            // quotient bits, q in 0..32768
    localparam int STEP_W  = 4;

    localparam logic signed [COORD_W-1:0] COORD_MAX_POS = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MAX_NEG = 32'sh8000_0000;
    localparam logic signed [NORM_W-1:0]  Q14_ONE       = 16'sd16384;

    // command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_NOT_LOADED = 2'd1;
    localparam logic [1:0] STAT_ZERO_EXT   = 2'd2;
    localparam logic [1:0] STAT_FULL       = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SIZE,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

### sv/vbn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbn_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module vbn_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/vertex_bbox_normalizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_bbox_normalizer_core
// Vertex store with running bounding box; reads map a vertex into [-1, +1].
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): s_tuser carries the command (clear, load, read),
//   s_tdata the x/y/z Q16.16 coordinates and the read index. Items are
//   taken one at a time; s_tready is high while no item is in progress.
//   Output stream (m_*): one item per read and per dropped load, with the
//   normalized Q2.14 x/y/z in m_tdata and the status code in m_tuser.
//   Clear and accepted loads finish in the accept cycle and return nothing.
//   A read of an unloaded index or a load into a full store goes to ST_OUT
//   and shows its item from the output register. A good read runs through
//   RAM fetch, extent and offset, size select, 16 restoring-divide steps (one
//   quotient bit a cycle, three axes in parallel) and the output load.
//   The output register decouples the sides: a new item is taken while the
//   last result waits; if the receiver stalls, the next result parks in
//   ST_OUT and the block stops accepting until the output slot frees up.
//   Reset (aresetn, synchronous) empties the set and the bounding box. The
//   vertex RAM is not cleared; only entries below the count are ever used.
// ----------------------------------------------------------------------------
module vertex_bbox_normalizer_core
    import vbn_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: coord_x[31:0], coord_y[63:32], coord_z[95:64],
    //          read_index[105:96], zero pad [111:106]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,
    // s_tuser: cmd[1:0]
    input  logic [1:0]   s_tuser,
    // m_tdata: norm_x[15:0], norm_y[31:16], norm_z[47:32]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,
    // m_tuser: status[1:0]
    output logic [1:0]   m_tuser
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int XW = CW + INDEX_W;           // common width for index check
    localparam int VW = AXES * COORD_W;

    state_t state_reg, state_next;

    logic [CW-1:0]               count_reg, count_next;
    logic signed [COORD_W-1:0]   min_reg [AXES];
    logic signed [COORD_W-1:0]   min_next [AXES];
    logic signed [COORD_W-1:0]   max_reg [AXES];
    logic signed [COORD_W-1:0]   max_next [AXES];
    logic [COORD_W-1:0]          ext_reg [AXES];
    logic [COORD_W-1:0]          ext_next [AXES];
    logic [COORD_W:0]            rem_reg [AXES];
    logic [COORD_W:0]            rem_next [AXES];
    logic [QBITS-1:0]            q_reg [AXES];
    logic [QBITS-1:0]            q_next [AXES];
    logic [COORD_W-1:0]          size_reg, size_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [1:0]                  status_reg, status_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [47:0]                 m_tdata_reg, m_tdata_next;
    logic [1:0]                  m_tuser_reg, m_tuser_next;

    logic                        s_acc;
    logic                        store_full;
    logic                        idx_bad;
    logic                        size_zero;
    logic                        out_free;
    logic [XW-1:0]               idx_ext;
    logic                        ram_we;
    logic                        ram_re;
    logic [VW-1:0]               ram_rdata;
    logic [COORD_W-1:0]          size_xy;

    assign s_acc      = s_tvalid && s_tready;
    assign idx_ext    = XW'(s_tdata[3*COORD_W +: INDEX_W]);
    assign store_full = (count_reg == CW'(MAX_VERTICES));
    assign idx_bad    = (idx_ext >= XW'(count_reg));
    assign size_zero  = (ext_reg[0] == '0) && (ext_reg[1] == '0) && (ext_reg[2] == '0);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign size_xy    = (ext_reg[1] > ext_reg[0]) ? ext_reg[1] : ext_reg[0];

    vbn_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_tdata[VW-1:0]),
        .re    (ram_re),
        .raddr (idx_ext[AW-1:0]),
        .rdata (ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    case (s_tuser)
                        CMD_LOAD: begin
                            if (store_full) begin
                                state_next = ST_OUT;
                            end
                        end
                        CMD_READ: begin
                            state_next = idx_bad ? ST_OUT : ST_FETCH;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FETCH: state_next = ST_SIZE;
            ST_SIZE:  state_next = size_zero ? ST_OUT : ST_DIV;
            ST_DIV: begin
                if (step_reg == '0) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        ram_we   = s_acc && (s_tuser == CMD_LOAD) && !store_full;
        ram_re   = s_acc && (s_tuser == CMD_READ);
    end

    // datapath
    always_comb begin
        logic [COORD_W:0] trial;
        logic             ge;
        logic signed [COORD_W-1:0] v;

        trial         = '0;
        ge            = 1'b0;
        v             = '0;
        count_next    = count_reg;
        size_next     = size_reg;
        step_next     = step_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        for (int a = 0; a < AXES; a++) begin
            min_next[a] = min_reg[a];
            max_next[a] = max_reg[a];
            ext_next[a] = ext_reg[a];
            rem_next[a] = rem_reg[a];
            q_next[a]   = q_reg[a];
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    case (s_tuser)
                        CMD_CLEAR: begin
                            count_next = '0;
                            for (int a = 0; a < AXES; a++) begin
                                min_next[a] = COORD_MAX_POS;
                                max_next[a] = COORD_MAX_NEG;
                            end
                        end
                        CMD_LOAD: begin
                            if (store_full) begin
                                status_next = STAT_FULL;
                            end else begin
                                count_next = count_reg + CW'(1);
                                for (int a = 0; a < AXES; a++) begin
                                    v = $signed(s_tdata[a*COORD_W +: COORD_W]);
                                    if (v < min_reg[a]) begin
                                        min_next[a] = v;
                                    end
                                    if (v > max_reg[a]) begin
                                        max_next[a] = v;
                                    end
                                end
                            end
                        end
                        CMD_READ: begin
                            status_next = STAT_NOT_LOADED;
                        end
                        default: begin
                            status_next = status_reg;
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                // offsets and extents are non-negative once a vertex is loaded
                for (int a = 0; a < AXES; a++) begin
                    v = $signed(ram_rdata[a*COORD_W +: COORD_W]);
                    rem_next[a] = {v[COORD_W-1], v} - {min_reg[a][COORD_W-1], min_reg[a]};
                    ext_next[a] = COORD_W'({max_reg[a][COORD_W-1], max_reg[a]}
                                           - {min_reg[a][COORD_W-1], min_reg[a]});
                end
            end
            ST_SIZE: begin
                size_next   = (ext_reg[2] > size_xy) ? ext_reg[2] : size_xy;
                step_next   = STEP_W'(QBITS - 1);
                status_next = size_zero ? STAT_ZERO_EXT : STAT_OK;
            end
            ST_DIV: begin
                // restoring divide of off*2^15 by size; first step uses off as is
                for (int a = 0; a < AXES; a++) begin
                    trial = (step_reg == STEP_W'(QBITS - 1)) ? rem_reg[a]
                          : {rem_reg[a][COORD_W-1:0], 1'b0};
                    ge    = (trial >= {1'b0, size_reg});
                    rem_next[a] = ge ? (trial - {1'b0, size_reg}) : trial;
                    q_next[a]   = {q_reg[a][QBITS-2:0], ge};
                end
                step_next = step_reg - STEP_W'(1);
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    for (int a = 0; a < AXES; a++) begin
                        case (status_reg)
                            STAT_OK: begin
                                m_tdata_next[a*NORM_W +: NORM_W] = q_reg[a] - Q14_ONE;
                            end
                            STAT_ZERO_EXT: begin
                                m_tdata_next[a*NORM_W +: NORM_W] = -Q14_ONE;
                            end
                            default: begin
                                m_tdata_next[a*NORM_W +: NORM_W] = '0;
                            end
                        endcase
                    end
                end
            end
            default: begin
                step_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                min_reg[a] <= COORD_MAX_POS;
                max_reg[a] <= COORD_MAX_NEG;
            end
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            for (int a = 0; a < AXES; a++) begin
                min_reg[a] <= min_next[a];
                max_reg[a] <= max_next[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        size_reg    <= size_next;
        step_reg    <= step_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        for (int a = 0; a < AXES; a++) begin
            ext_reg[a] <= ext_next[a];
            rem_reg[a] <= rem_next[a];
            q_reg[a]   <= q_next[a];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_VERTICES))
        else $error("vertex count above store depth");

    a_bbox_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> (min_reg[0] <= max_reg[0]) && (min_reg[1] <= max_reg[1])
                              && (min_reg[2] <= max_reg[2]))
        else $error("bounding box min above max with vertices loaded");

    a_rem_below_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && step_reg != STEP_W'(QBITS - 1))
        |-> (rem_reg[0] < {1'b0, size_reg}) && (rem_reg[1] < {1'b0, size_reg})
            && (rem_reg[2] < {1'b0, size_reg}))
        else $error("divider remainder not below divisor");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg == STAT_OK)
        |-> ($signed(m_tdata_reg[15:0]) >= -Q14_ONE) && ($signed(m_tdata_reg[15:0]) <= Q14_ONE)
            && ($signed(m_tdata_reg[31:16]) >= -Q14_ONE)
            && ($signed(m_tdata_reg[31:16]) <= Q14_ONE)
            && ($signed(m_tdata_reg[47:32]) >= -Q14_ONE)
            && ($signed(m_tdata_reg[47:32]) <= Q14_ONE))
        else $error("normalized value outside -1.0 .. +1.0");

endmodule
